FILE: hw/rtl/jsu_pkg.sv
package jsu_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;   // power of two
    localparam int MAX_BYTES         = 4;

    typedef enum logic [3:0] {
        ST_BYTE       = 4'd0,
        ST_DONE       = 4'd1,
        ST_NO_QUOTE   = 4'd2,
        ST_CONTROL    = 4'd3,
        ST_BAD_ESC    = 4'd4,
        ST_BAD_HEX    = 4'd5,
        ST_NO_LOW     = 4'd6,
        ST_BAD_LOW    = 4'd7,
        ST_UNTERM     = 4'd8,
        ST_INC_ESC    = 4'd9,
        ST_INC_UNI    = 4'd10
    } status_t;

    // All results caused by one item, in delivery order from bytes[0]
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                last_idx;
        status_t                   status;
        logic [15:0]               position;
    } group_t;

endpackage

FILE: hw/rtl/jsu_front.sv
module jsu_front
    import jsu_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] text_byte,
    input  logic       text_end,
    output logic       push,
    output group_t     grp
);

    localparam int W = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;
    localparam logic [W-1:0] PMAX_W = {{(W-POSITION_BITS){1'b0}}, {POSITION_BITS{1'b1}}};
    localparam logic [POSITION_BITS-1:0] PMAX = {POSITION_BITS{1'b1}};

    typedef enum logic [3:0] {
        M_START   = 4'd0,
        M_DONE    = 4'd1,
        M_IGNORE  = 4'd2,
        M_STR     = 4'd3,
        M_ESC     = 4'd4,
        M_HEX1    = 4'd5,
        M_WANT_BS = 4'd6,
        M_WANT_U  = 4'd7,
        M_HEX2    = 4'd8
    } mode_t;

    mode_t                    mode_reg, mode_next;
    logic [15:0]              acc_reg, acc_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic                     bad_reg, bad_next;
    logic [9:0]               hs_reg, hs_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic                     emit;
    group_t                   g;
    logic [4:0]               hv;
    logic [20:0]              pair_cp;

    function automatic logic [15:0] pos_rel(input logic [POSITION_BITS-1:0] cur,
                                            input logic [1:0] back,
                                            input logic [2:0] fwd);
        logic [W-1:0] c;
        logic [W-1:0] v;
        c = W'(cur);
        if (c >= PMAX_W) begin
            v = PMAX_W;
        end else begin
            v = (c >= W'(back)) ? c - W'(back) : '0;
            v = v + W'(fwd);
            if (v > PMAX_W) begin
                v = PMAX_W;
            end
        end
        return (v > W'(17'h0FFFF)) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd16;
        if (c >= "0" && c <= "9") begin
            r = 5'(c - 8'h30);
        end else if (c >= "a" && c <= "f") begin
            r = 5'(c - 8'h57);
        end else if (c >= "A" && c <= "F") begin
            r = 5'(c - 8'h37);
        end
        return r;
    endfunction

    function automatic group_t utf8(input logic [20:0] cp);
        group_t r;
        r = '0;
        r.status = ST_BYTE;
        if (cp <= 21'h7F) begin
            r.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.last_idx = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.last_idx = 2'd2;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

    assign hv = hex_value(text_byte);

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        bad_next  = bad_reg;
        hs_next   = hs_reg;
        pos_next  = pos_reg;
        emit      = 1'b0;
        g         = '0;
        g.status  = ST_BYTE;
        pair_cp   = '0;

        if (text_end) begin
            case (mode_reg)
                M_START: begin
                    emit = 1'b1; g.status = ST_NO_QUOTE;
                    g.position = pos_rel(pos_reg, 2'd0, 3'd0);
                end
                M_STR: begin
                    emit = 1'b1; g.status = ST_UNTERM;
                    g.position = pos_rel(pos_reg, 2'd0, 3'd0);
                end
                M_ESC: begin
                    emit = 1'b1; g.status = ST_INC_ESC;
                    g.position = pos_rel(pos_reg, 2'd0, 3'd0);
                end
                M_HEX1, M_HEX2: begin
                    emit = 1'b1; g.status = ST_INC_UNI;
                    g.position = pos_rel(pos_reg, cnt_reg, 3'd0);
                end
                M_WANT_BS: begin
                    emit = 1'b1; g.status = ST_NO_LOW;
                    g.position = pos_rel(pos_reg, 2'd0, 3'd0);
                end
                M_WANT_U: begin
                    emit = 1'b1; g.status = ST_NO_LOW;
                    g.position = pos_rel(pos_reg, 2'd1, 3'd0);
                end
                default: ;
            endcase
            // end of text: back to the reset state
            mode_next = M_START;
            acc_next  = '0;
            cnt_next  = '0;
            bad_next  = 1'b0;
            hs_next   = '0;
            pos_next  = '0;
        end else begin
            pos_next = (pos_reg == PMAX) ? pos_reg : pos_reg + POSITION_BITS'(1);
            case (mode_reg)
                M_START, M_DONE: begin
                    if (text_byte == "\"") begin
                        mode_next = M_STR;
                    end else begin
                        emit = 1'b1; g.status = ST_NO_QUOTE;
                        g.position = pos_rel(pos_reg, 2'd0, 3'd0);
                        mode_next = M_IGNORE;
                        acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                    end
                end
                M_STR: begin
                    if (text_byte == "\"") begin
                        mode_next = M_DONE;
                        emit = 1'b1; g.status = ST_DONE;
                    end else if (text_byte < 8'h20) begin
                        emit = 1'b1; g.status = ST_CONTROL;
                        g.position = pos_rel(pos_reg, 2'd0, 3'd1);
                        mode_next = M_IGNORE;
                        acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                    end else if (text_byte == "\\") begin
                        mode_next = M_ESC;
                    end else begin
                        emit = 1'b1; g.bytes[0] = text_byte;
                    end
                end
                M_ESC: begin
                    mode_next = M_STR;
                    emit      = 1'b1;
                    case (text_byte)
                        "\"", "\\", "/": g.bytes[0] = text_byte;
                        "b":             g.bytes[0] = 8'h08;
                        "f":             g.bytes[0] = 8'h0C;
                        "n":             g.bytes[0] = 8'h0A;
                        "r":             g.bytes[0] = 8'h0D;
                        "t":             g.bytes[0] = 8'h09;
                        "u": begin
                            emit = 1'b0;
                            mode_next = M_HEX1;
                            acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                        end
                        default: begin
                            g.status = ST_BAD_ESC;
                            g.position = pos_rel(pos_reg, 2'd0, 3'd1);
                            mode_next = M_IGNORE;
                            acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                        end
                    endcase
                end
                M_HEX1, M_HEX2: begin
                    // after a bad digit the accumulator keeps that digit's index
                    if (!bad_reg) begin
                        if (hv < 5'd16) begin
                            acc_next = {acc_reg[11:0], hv[3:0]};
                        end else begin
                            bad_next = 1'b1;
                            acc_next = {14'd0, cnt_reg};
                        end
                    end
                    if (cnt_reg != 2'd3) begin
                        cnt_next = cnt_reg + 2'd1;
                    end else if (bad_next) begin
                        emit = 1'b1; g.status = ST_BAD_HEX;
                        g.position = pos_rel(pos_reg, 2'd3, {1'b0, acc_next[1:0]} + 3'd1);
                        mode_next = M_IGNORE;
                        acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                    end else if (mode_reg == M_HEX1) begin
                        if (acc_next >= 16'hD800 && acc_next <= 16'hDBFF) begin
                            hs_next   = acc_next[9:0];
                            mode_next = M_WANT_BS;
                        end else begin
                            emit = 1'b1;
                            g = utf8({5'd0, acc_next});
                            mode_next = M_STR;
                        end
                        acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                    end else begin
                        if (acc_next < 16'hDC00 || acc_next > 16'hDFFF) begin
                            emit = 1'b1; g.status = ST_BAD_LOW;
                            g.position = pos_rel(pos_reg, 2'd0, 3'd1);
                            mode_next = M_IGNORE;
                        end else begin
                            pair_cp = 21'h10000 + {1'b0, hs_reg, acc_next[9:0]};
                            emit = 1'b1;
                            g = utf8(pair_cp);
                            mode_next = M_STR;
                        end
                        acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                    end
                end
                M_WANT_BS: begin
                    if (text_byte == "\\") begin
                        mode_next = M_WANT_U;
                    end else begin
                        emit = 1'b1; g.status = ST_NO_LOW;
                        g.position = pos_rel(pos_reg, 2'd0, 3'd0);
                        mode_next = M_IGNORE;
                        acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                    end
                end
                M_WANT_U: begin
                    if (text_byte == "u") begin
                        mode_next = M_HEX2;
                        acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                    end else begin
                        emit = 1'b1; g.status = ST_NO_LOW;
                        g.position = pos_rel(pos_reg, 2'd1, 3'd0);
                        mode_next = M_IGNORE;
                        acc_next = '0; cnt_next = '0; bad_next = 1'b0;
                    end
                end
                default: mode_next = M_IGNORE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_START;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            bad_reg  <= 1'b0;
            hs_reg   <= '0;
            pos_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            bad_reg  <= bad_next;
            hs_reg   <= hs_next;
            pos_reg  <= pos_next;
        end
    end

    assign push = accept && emit;
    assign grp  = g;

endmodule

FILE: hw/rtl/jsu_queue.sv
module jsu_queue
    import jsu_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  group_t push_grp,
    input  logic   pop,
    output group_t head,
    output logic   not_empty,
    output logic   not_full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    group_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers wrap naturally: depth is a power of two
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_grp;
        end
    end

endmodule

FILE: hw/rtl/jsu_back.sv
module jsu_back
    import jsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  group_t      head,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [3:0]  m_status,
    output logic [15:0] m_byte_position,
    output logic        m_last_of_run
);

    logic [1:0] idx_reg;
    logic       last;
    logic       fire;

    assign last            = (idx_reg == head.last_idx);
    assign fire            = head_valid && m_ready;
    assign pop             = fire && last;
    assign m_valid         = head_valid;
    assign m_out_byte      = head.bytes[idx_reg];
    assign m_status        = head.status;
    assign m_byte_position = head.position;
    assign m_last_of_run   = last;

    // step through the bytes of the head group, drop it after the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (fire) begin
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

FILE: hw/rtl/json_string_unescape_utf8.sv
// JSON string unescaper: takes one text byte per accepted item (s_text_end marks end of
// text) and delivers the decoded UTF-8 bytes of one quoted string, then a done or error
// result, each result with m_last_of_run set on the last result an item caused. The
// decoder takes one item per cycle while s_ready is high and registers its results in
// the queue. An item makes 0 to 4 results, and the result port sends one per cycle
// while m_ready is high, so a \u escape holds the result side for one result per UTF-8
// byte. A two-group queue between decoder and result port sets how long the input may
// run ahead: s_ready drops only while both groups are waiting. Error positions count
// text bytes and saturate at 2^POSITION_BITS - 1, reported saturated at 65535.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_text_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [3:0]  m_status,
    output logic [15:0] m_byte_position,
    output logic        m_last_of_run
);

    logic   accept;
    logic   push;
    group_t push_grp;
    group_t head;
    logic   head_valid;
    logic   pop;
    logic   not_full;

    assign s_ready = not_full;
    assign accept  = s_valid && not_full;

    jsu_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .text_byte (s_text_byte),
        .text_end  (s_text_end),
        .push      (push),
        .grp       (push_grp)
    );

    jsu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_grp  (push_grp),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .not_full  (not_full)
    );

    jsu_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .head_valid      (head_valid),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_status        (m_status),
        .m_byte_position (m_byte_position),
        .m_last_of_run   (m_last_of_run)
    );

endmodule

FILE: hw/rtl/jsu_checker.sv
module jsu_checker
    import jsu_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic [3:0]  m_status,
    input logic [15:0] m_byte_position,
    input logic        m_last_of_run
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_status)
            && $stable(m_byte_position) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    // done and error results stand alone
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_BYTE) |-> m_last_of_run)
        else $error("status result not last of run");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_BYTE) |-> (m_out_byte == 8'd0))
        else $error("status result carries a byte");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_BYTE || m_status == ST_DONE) |-> (m_byte_position == 16'd0))
        else $error("position set on byte or done result");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_byte      (m_out_byte),
    .m_status        (m_status),
    .m_byte_position (m_byte_position),
    .m_last_of_run   (m_last_of_run)
);
